FILE: hdl/vbr_delta_audio_decoder_assert.svh
// ----------------------------------------------------------------------------
// vbr_delta_audio_decoder_assert.svh
// Assertion macros shared by the decoder's checker.
// ----------------------------------------------------------------------------
`ifndef VBR_DELTA_AUDIO_DECODER_ASSERT_SVH
`define VBR_DELTA_AUDIO_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define VDA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define VDA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/vda_pkg.sv
// ----------------------------------------------------------------------------
// vda_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package vda_pkg;

    localparam int COUNT_BITS      = 24;
    localparam int MAX_SILENCE_RUN = 16;
    localparam int RUN_W           = 5;
    localparam int MAX_RESULTS     = 32;
    localparam int RES_CNT_W       = 6;
    localparam int HOLD_W          = 20;
    localparam int HELD_W          = 5;
    localparam int CODE_BITS       = 4;
    localparam int FIELD_W         = 12;
    localparam int SAMPLE_W        = 16;
    localparam int BYTE_W          = 8;
    localparam int CFG_IDX_W       = 1;
    localparam int HOLD_FILL_MAX   = 12;

    // bitstream codes
    localparam logic [CODE_BITS-1:0] CODE_SIL_SHORT = 4'd0;
    localparam logic [CODE_BITS-1:0] CODE_SIL_LONG  = 4'd1;
    localparam logic [CODE_BITS-1:0] CODE_DELTA_MAX = 4'd11;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RUN_SHORT = 1'b0,
        REG_RUN_LONG  = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PH_SCALE = 2'd0,
        PH_LOW   = 2'd1,
        PH_HIGH  = 2'd2,
        PH_BITS  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_RUN   = 2'd1,
        ST_FLUSH = 2'd2
    } ctrl_state_t;

    typedef struct packed {
        logic load;   // take the input byte
        logic step;   // one decode step
        logic flush;  // push held result as last of the byte
    } dp_cmd_t;

    typedef struct packed {
        logic byte_runs;   // offered byte feeds the bitstream decode
        logic byte_emits;  // offered byte completes the first sample
        logic step_ok;     // a decode step can run now
        logic step_emits;  // that step yields a result
        logic pend_valid;  // a result is held back for the last flag
        logic out_free;    // output register can take a result
    } dp_status_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [BYTE_W-1:0]   scale;
        logic                done;
        logic                bad;
    } result_t;

endpackage

FILE: hdl/vda_ctrl.sv
// ----------------------------------------------------------------------------
// vda_ctrl
// Sequencer: accepts a byte, steps the decode loop, flushes the last result.
// ----------------------------------------------------------------------------
module vda_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output vda_pkg::dp_cmd_t    cmd,
    input  vda_pkg::dp_status_t status
);
    import vda_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (status.byte_runs)
                    begin
                        state_next = ST_RUN;
                    end
                    else if (status.byte_emits)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_RUN:
            begin
                if (!status.step_ok)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!status.pend_valid || status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_RUN:
            begin
                // a step that displaces a held result needs room at the output
                cmd.step = status.step_ok
                         && (!status.step_emits || !status.pend_valid || status.out_free);
            end
            ST_FLUSH:
            begin
                cmd.flush = status.pend_valid && status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

FILE: hdl/vda_datapath.sv
// ----------------------------------------------------------------------------
// vda_datapath
// Decoder state, bit holding register, one decode step, result staging.
// ----------------------------------------------------------------------------
module vda_datapath (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_write,
    input  logic [vda_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [vda_pkg::RUN_W-1:0]                cfg_data,
    input  logic [vda_pkg::BYTE_W-1:0]               stream_byte,
    input  logic                                     packet_start,
    input  logic [vda_pkg::COUNT_BITS-1:0]           sample_total,
    input  vda_pkg::dp_cmd_t                         cmd,
    output vda_pkg::dp_status_t                      status,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic signed [vda_pkg::SAMPLE_W-1:0]      sample,
    output logic [vda_pkg::BYTE_W-1:0]               scale,
    output logic                                     packet_done,
    output logic                                     bad_code,
    output logic                                     last
);
    import vda_pkg::*;

    // configuration
    logic [RUN_W-1:0] run_short_reg;
    logic [RUN_W-1:0] run_long_reg;
    logic [RUN_W-1:0] cfg_sat;

    // decoder state
    phase_t                phase_reg,    phase_next;
    logic [BYTE_W-1:0]     scale_reg,    scale_next;
    logic [SAMPLE_W-1:0]   run_reg,      run_next;
    logic [COUNT_BITS-1:0] left_reg,     left_next;
    logic                  dmode_reg,    dmode_next;
    logic [CODE_BITS-1:0]  dwidth_reg,   dwidth_next;
    logic [RUN_W-1:0]      sil_reg,      sil_next;
    logic [HOLD_W-1:0]     hold_reg,     hold_next;
    logic [HELD_W-1:0]     held_reg,     held_next;
    logic                  stopped_reg,  stopped_next;
    logic [RES_CNT_W-1:0]  count_reg,    count_next;

    // staging
    logic    pend_valid_reg, pend_valid_next;
    result_t pend_reg,       pend_next;
    logic    out_valid_reg,  out_valid_next;
    result_t out_reg,        out_next;
    logic    out_last_reg,   out_last_next;

    // step datapath
    logic [CODE_BITS-1:0] need_w;
    logic                 silence_on;
    logic                 enough;
    logic [FIELD_W-1:0]   field_mask;
    logic [FIELD_W-1:0]   field;
    logic [FIELD_W-1:0]   sign_bit;
    logic [CODE_BITS-1:0] code;
    logic                 delta_end;
    logic [SAMPLE_W-1:0]  delta_ext;
    logic [SAMPLE_W-1:0]  delta_sum;
    logic                 code_bad;
    logic                 step_emits;
    result_t              step_res;
    logic                 out_free;

    assign cfg_sat = (cfg_data > RUN_W'(MAX_SILENCE_RUN)) ? RUN_W'(MAX_SILENCE_RUN) : cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_short_reg <= RUN_W'(4);
            run_long_reg  <= RUN_W'(16);
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_RUN_SHORT: run_short_reg <= cfg_sat;
                REG_RUN_LONG:  run_long_reg  <= cfg_sat;
                default:       run_short_reg <= run_short_reg;
            endcase
        end
    end

    // one step: silence sample, delta field, or 4-bit code
    assign need_w     = dmode_reg ? dwidth_reg : CODE_BITS[CODE_BITS-1:0];
    assign silence_on = (sil_reg != '0);
    assign enough     = (held_reg >= HELD_W'(need_w));
    assign field_mask = ~({FIELD_W{1'b1}} << need_w);
    assign field      = hold_reg[FIELD_W-1:0] & field_mask;
    assign sign_bit   = FIELD_W'(1) << (need_w - CODE_BITS'(1));
    assign code       = hold_reg[CODE_BITS-1:0];
    assign delta_end  = (field == sign_bit);
    assign delta_ext  = {{(SAMPLE_W-FIELD_W){1'b0}}, field}
                      | (((field & sign_bit) != '0)
                         ? ~{{(SAMPLE_W-FIELD_W){1'b0}}, field_mask} : '0);
    assign delta_sum  = run_reg + delta_ext;
    assign code_bad   = (code > CODE_DELTA_MAX);

    assign step_emits = silence_on || (dmode_reg && !delta_end) || (!dmode_reg && code_bad);

    always_comb
    begin
        step_res.scale  = scale_reg;
        step_res.bad    = !silence_on && !dmode_reg;
        step_res.sample = (!silence_on && dmode_reg) ? delta_sum : '0;
        step_res.done   = step_res.bad || (left_reg == COUNT_BITS'(1));
    end

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        status.byte_runs  = !packet_start && (phase_reg == PH_BITS)
                          && (left_reg != '0) && !stopped_reg;
        status.byte_emits = !packet_start && (phase_reg == PH_HIGH) && (left_reg != '0);
        status.step_ok    = (left_reg != '0) && !stopped_reg
                          && (count_reg < RES_CNT_W'(MAX_RESULTS))
                          && (silence_on || enough);
        status.step_emits = step_emits;
        status.pend_valid = pend_valid_reg;
        status.out_free   = out_free;
    end

    always_comb
    begin
        phase_next      = phase_reg;
        scale_next      = scale_reg;
        run_next        = run_reg;
        left_next       = left_reg;
        dmode_next      = dmode_reg;
        dwidth_next     = dwidth_reg;
        sil_next        = sil_reg;
        hold_next       = hold_reg;
        held_next       = held_reg;
        stopped_next    = stopped_reg;
        count_next      = count_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.load)
        begin
            count_next = '0;
            if (packet_start)
            begin
                scale_next   = stream_byte;
                left_next    = sample_total;
                phase_next   = PH_LOW;
                run_next     = '0;
                dmode_next   = 1'b0;
                dwidth_next  = '0;
                sil_next     = '0;
                hold_next    = '0;
                held_next    = '0;
                stopped_next = 1'b0;
            end
            else
            begin
                case (phase_reg)
                    PH_LOW:
                    begin
                        run_next   = {{(SAMPLE_W-BYTE_W){1'b0}}, stream_byte};
                        phase_next = PH_HIGH;
                    end
                    PH_HIGH:
                    begin
                        run_next   = {stream_byte, run_reg[BYTE_W-1:0]};
                        phase_next = PH_BITS;
                        if (left_reg != '0)
                        begin
                            left_next        = left_reg - COUNT_BITS'(1);
                            pend_valid_next  = 1'b1;
                            pend_next.sample = {stream_byte, run_reg[BYTE_W-1:0]};
                            pend_next.scale  = scale_reg;
                            pend_next.done   = (left_reg == COUNT_BITS'(1));
                            pend_next.bad    = 1'b0;
                        end
                    end
                    PH_BITS:
                    begin
                        if ((left_reg != '0) && !stopped_reg
                            && (held_reg <= HELD_W'(HOLD_FILL_MAX)))
                        begin
                            hold_next = hold_reg | (HOLD_W'(stream_byte) << held_reg);
                            held_next = held_reg + HELD_W'(BYTE_W);
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end

        if (cmd.step)
        begin
            if (silence_on)
            begin
                sil_next = sil_reg - RUN_W'(1);
            end
            else
            begin
                hold_next = hold_reg >> need_w;
                held_next = held_reg - HELD_W'(need_w);
                if (dmode_reg)
                begin
                    if (delta_end)
                    begin
                        dmode_next = 1'b0;
                    end
                    else
                    begin
                        run_next = delta_sum;
                    end
                end
                else if (code == CODE_SIL_SHORT || code == CODE_SIL_LONG)
                begin
                    run_next = '0;
                    sil_next = (code == CODE_SIL_SHORT) ? run_short_reg : run_long_reg;
                end
                else if (!code_bad)
                begin
                    dwidth_next = code + CODE_BITS'(1);
                    dmode_next  = 1'b1;
                end
                else
                begin
                    stopped_next = 1'b1;
                end
            end

            if (step_emits)
            begin
                left_next  = step_res.bad ? '0 : (left_reg - COUNT_BITS'(1));
                count_next = count_reg + RES_CNT_W'(1);
                if (pend_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_next       = pend_reg;
                    out_last_next  = 1'b0;
                end
                pend_valid_next = 1'b1;
                pend_next       = step_res;
            end
        end

        if (cmd.flush)
        begin
            out_valid_next  = 1'b1;
            out_next        = pend_reg;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SCALE;
            scale_reg      <= '0;
            run_reg        <= '0;
            left_reg       <= '0;
            dmode_reg      <= 1'b0;
            dwidth_reg     <= '0;
            sil_reg        <= '0;
            hold_reg       <= '0;
            held_reg       <= '0;
            stopped_reg    <= 1'b0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            scale_reg      <= scale_next;
            run_reg        <= run_next;
            left_reg       <= left_next;
            dmode_reg      <= dmode_next;
            dwidth_reg     <= dwidth_next;
            sil_reg        <= sil_next;
            hold_reg       <= hold_next;
            held_reg       <= held_next;
            stopped_reg    <= stopped_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign sample      = out_reg.sample;
    assign scale       = out_reg.scale;
    assign packet_done = out_reg.done;
    assign bad_code    = out_reg.bad;
    assign last        = out_last_reg;

endmodule

FILE: hdl/vbr_delta_audio_decoder.sv
// ----------------------------------------------------------------------------
// vbr_delta_audio_decoder
// Streaming variable-width delta PCM decoder, one packet byte per transfer.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one packet byte per transfer. packet_start
// marks the scale byte and carries sample_total; the next two bytes are the
// first sample (low, high), then a bitstream of 4-bit codes, LSB first.
// Output channel (out_valid/out_ready): one decoded sample per transfer with
// the packet's scale, packet_done on the final sample, bad_code on a reserved
// code, and last on the final result caused by the byte.
// Config port: cfg_write/cfg_index/cfg_data set the short and long silence
// run lengths (saturated to 16); write only while the decoder is idle.
// Flow: a header byte is taken in idle alone; the high first-sample byte also
// passes through flush. A bitstream byte runs the step loop (a decode step per
// emitted sample, per code read, per run-ending delta), then flush; the single
// step unit does one step per cycle: up to 32 samples leave at one per cycle.
// in_ready is high only between bytes. One result is held back per byte so
// its last flag is known; a stalled receiver simply stops the step loop.
// Reset: silence runs return to 4 and 16, decoder waits for a scale byte.
// ----------------------------------------------------------------------------
module vbr_delta_audio_decoder (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write,
    input  logic [vda_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [vda_pkg::RUN_W-1:0]              cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [vda_pkg::BYTE_W-1:0]             stream_byte,
    input  logic                                   packet_start,
    input  logic [vda_pkg::COUNT_BITS-1:0]         sample_total,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [vda_pkg::SAMPLE_W-1:0]    sample,
    output logic [vda_pkg::BYTE_W-1:0]             scale,
    output logic                                   packet_done,
    output logic                                   bad_code,
    output logic                                   last
);
    import vda_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer: idle / step loop / final flush
    vda_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .status   (status)
    );

    // state, step unit and output staging
    vda_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .stream_byte  (stream_byte),
        .packet_start (packet_start),
        .sample_total (sample_total),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sample       (sample),
        .scale        (scale),
        .packet_done  (packet_done),
        .bad_code     (bad_code),
        .last         (last)
    );

endmodule

FILE: hdl/vda_checker.sv
// ----------------------------------------------------------------------------
// vda_checker
// Port-level checks on the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "vbr_delta_audio_decoder_assert.svh"

module vda_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [vda_pkg::SAMPLE_W-1:0] sample,
    input logic [vda_pkg::BYTE_W-1:0]          scale,
    input logic                                packet_done,
    input logic                                bad_code,
    input logic                                last
);

    // stalled result holds
    `VDA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(sample) && $stable(scale) && $stable(last), "stalled result changed")

    // reserved code ends the packet with a zero sample
    `VDA_ASSERT_NOW(a_bad_done, out_valid && bad_code, packet_done && (sample == 16'sd0), "bad code result malformed")

    // final sample of a packet closes its byte
    `VDA_ASSERT_NOW(a_done_last, out_valid && packet_done, last, "packet end without last")

endmodule

bind vbr_delta_audio_decoder vda_checker u_vda_checker (.*);
